// ===== src/mbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the multiplexed one-bit pulse synthesizer.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int OP_W     = 2;
    localparam int CH_IDX_W = 3;
    localparam int STEP_W   = 16;
    localparam int PULSE_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int PERIOD_W = 5;
    localparam int TIMER_W  = 16;
    localparam int BYTE_W   = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(15);
    localparam logic [TIMER_W-1:0]  TIMER_MAX    = {TIMER_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_SET_CH = 2'd1,
        OP_LOAD   = 2'd2,
        OP_START  = 2'd3
    } t_op;

    // One result transfer
    typedef struct packed {
        logic audio_bit;
        logic sample_mode;
    } t_result;

    // Channel bank control for one item
    typedef struct packed {
        logic                tick;
        logic                set;
        logic [CH_IDX_W-1:0] idx;
        logic [STEP_W-1:0]   step;
        logic [PULSE_W-1:0]  pulse;
        logic                on;
    } t_chan_cmd;

    // Sample player control for one item (address travels separately)
    typedef struct packed {
        logic                tick;
        logic                load;
        logic                start;
        logic                load_bit;
        logic [COUNT_W-1:0]  count;
        logic [PERIOD_W-1:0] period;
    } t_play_cmd;

endpackage
`default_nettype wire

// ===== src/mbps_chan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_chan
// Round-robin channel bank: phase accumulators and the shared pulse timer.
// ----------------------------------------------------------------------------
module mbps_chan #(
    parameter int NUM_CHANNELS = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mbps_pkg::t_chan_cmd i_cmd,
    output logic                     o_level
);
    import mbps_pkg::*;

    localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [STEP_W-1:0]  r_phase [NUM_CHANNELS];
    logic [STEP_W-1:0]  r_step  [NUM_CHANNELS];
    logic [PULSE_W-1:0] r_pulse [NUM_CHANNELS];
    logic               r_en    [NUM_CHANNELS];
    logic [CHW-1:0]     r_cur;
    logic [TIMER_W-1:0] r_timer;

    logic [STEP_W:0]    phase_sum;
    logic [TIMER_W-1:0] timer_dec;
    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] n_timer;
    logic [CHW-1:0]     n_cur;
    logic               set_ok;

    assign o_level   = (r_timer != '0);
    assign phase_sum = {1'b0, r_phase[r_cur]} + {1'b0, r_step[r_cur]};
    assign timer_dec = o_level ? r_timer - TIMER_W'(1) : r_timer;
    assign timer_sum = {1'b0, timer_dec} + (TIMER_W + 1)'(r_pulse[r_cur]);
    assign set_ok    = i_cmd.set && ({1'b0, i_cmd.idx} < (CH_IDX_W + 1)'(NUM_CHANNELS));

    always_comb begin
        // carry out of the phase add means the phase wrapped
        if (phase_sum[STEP_W] && r_en[r_cur]) begin
            n_timer = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
        end else begin
            n_timer = timer_dec;
        end
        n_cur = (r_cur == CHW'(NUM_CHANNELS - 1)) ? '0 : r_cur + CHW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_phase[i] <= '0;
                r_step[i]  <= '0;
                r_pulse[i] <= '0;
                r_en[i]    <= 1'b0;
            end
            r_cur   <= '0;
            r_timer <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_phase[r_cur] <= phase_sum[STEP_W-1:0];
                r_timer        <= n_timer;
                r_cur          <= n_cur;
            end
            if (set_ok) begin
                r_step[i_cmd.idx[CHW-1:0]]  <= i_cmd.step;
                r_pulse[i_cmd.idx[CHW-1:0]] <= i_cmd.pulse;
                r_en[i_cmd.idx[CHW-1:0]]    <= i_cmd.on;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/mbps_play.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_play
// One-bit sample player: bit memory, prefetched read, period countdown.
// ----------------------------------------------------------------------------
module mbps_play #(
    parameter  int SAMPLE_DEPTH = 2048,
    localparam int AW           = $clog2(SAMPLE_DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mbps_pkg::t_play_cmd i_cmd,
    input  wire logic [AW-1:0]       i_load_addr,
    output logic                     o_playing,
    output logic                     o_bit
);
    import mbps_pkg::*;

    localparam int PW   = AW + 1;
    localparam int CMPW = (PW > COUNT_W) ? PW : COUNT_W;

    logic               mem [SAMPLE_DEPTH];
    logic               r_rd_bit;
    logic               r_playing, n_playing;
    logic [PW-1:0]      r_pos, n_pos;
    logic [COUNT_W-1:0] r_limit, n_limit;
    logic [PERIOD_W-1:0] r_cd, n_cd;
    logic               r_held, n_held;

    logic          bit_step;
    logic          has_len;
    logic [PW-1:0] pos_inc;

    assign bit_step  = (r_cd == '0);
    assign has_len   = (r_limit != '0);
    assign pos_inc   = r_pos + PW'(1);
    assign o_playing = r_playing;
    // bit shown by a tick taken now
    assign o_bit     = (bit_step && has_len) ? r_rd_bit : r_held;

    always_comb begin
        n_playing = r_playing;
        n_pos     = r_pos;
        n_limit   = r_limit;
        n_cd      = r_cd;
        n_held    = r_held;
        if (i_cmd.start) begin
            n_playing = 1'b1;
            n_limit   = i_cmd.count;
            n_pos     = '0;
            n_cd      = '0;
        end else if (i_cmd.tick) begin
            if (bit_step) begin
                if (has_len) begin
                    n_held = r_rd_bit;
                    n_pos  = pos_inc;
                    if ((CMPW'(pos_inc) >= CMPW'(r_limit)) ||
                        (pos_inc >= PW'(SAMPLE_DEPTH))) begin
                        n_playing = 1'b0;
                    end
                    n_cd = i_cmd.period;
                end else begin
                    n_playing = 1'b0;
                end
            end else begin
                n_cd = r_cd - PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_pos     <= '0;
            r_limit   <= '0;
            r_cd      <= '0;
            r_held    <= 1'b0;
        end else begin
            r_playing <= n_playing;
            r_pos     <= n_pos;
            r_limit   <= n_limit;
            r_cd      <= n_cd;
            r_held    <= n_held;
        end
    end

    // Sample memory: write port, plus a read of the next position so the
    // bit is ready on the following tick. Same-cycle write is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[i_load_addr] <= i_cmd.load_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_load_addr == n_pos[AW-1:0])) begin
            r_rd_bit <= i_cmd.load_bit;
        end else begin
            r_rd_bit <= mem[n_pos[AW-1:0]];
        end
    end

endmodule
`default_nettype wire

// ===== src/mbps_obuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_obuf
// Two-entry result buffer that decouples the core from the receiver stall.
// ----------------------------------------------------------------------------
module mbps_obuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mbps_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output mbps_pkg::t_result      o_data
);
    import mbps_pkg::*;

    logic [1:0] r_cnt;
    t_result    r_e0, r_e1;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_e0;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({i_push, pop})
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_e0 <= i_data;
                end else begin
                    r_e0 <= r_e1;
                    r_e1 <= i_data;
                end
            end
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_e0 <= i_data;
                end else begin
                    r_e1 <= i_data;
                end
            end
            2'b01: begin
                r_e0 <= r_e1;
            end
            default: begin
                r_e0 <= r_e0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/multiplexed_one_bit_pulse_synth.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_one_bit_pulse_synth
// One-bit pulse synthesizer with round-robin channels and sample playback.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   tick, set channel, load sample byte or start playback. Only a tick
//   yields a result, sent on the output channel (o_out_valid / i_out_stall)
//   as o_audio_bit and o_sample_mode.
//   The config channel (i_cfg_valid / o_cfg_ready) writes the playback bit
//   period; it is always ready and should be written while the block idles.
//   A tick's result passes the input register, then core logic into the
//   result buffer, before it is offered on the output channel.
//   Throughput: 1 item per cycle while o_in_stall is low, set by the
//   channel update and the prefetched one-read-per-cycle sample memory.
//   The two-entry result buffer keeps input flowing while one result waits;
//   when it fills and the receiver stalls, o_in_stall rises for ticks only
//   and other commands keep draining.
//   Reset (synchronous, active low) clears channels, timer, player state and
//   the buffer, and sets the bit period to 15. Sample memory is not cleared.
// ----------------------------------------------------------------------------
module multiplexed_one_bit_pulse_synth #(
    parameter  int NUM_CHANNELS = 6,
    parameter  int SAMPLE_DEPTH = 2048,
    localparam int AW           = $clog2(SAMPLE_DEPTH)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // command transfer
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [mbps_pkg::OP_W-1:0]        i_operation,
    input  wire logic [mbps_pkg::CH_IDX_W-1:0]    i_channel_index,
    input  wire logic [mbps_pkg::STEP_W-1:0]      i_step_value,
    input  wire logic [mbps_pkg::PULSE_W-1:0]     i_pulse_length,
    input  wire logic                             i_channel_on,
    input  wire logic [AW-1:0]                    i_sample_address,
    input  wire logic signed [mbps_pkg::BYTE_W-1:0] i_sample_byte,
    input  wire logic [mbps_pkg::COUNT_W-1:0]     i_sample_count,
    // result transfer
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_audio_bit,
    output logic                                  o_sample_mode,
    // config write
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mbps_pkg::PERIOD_W-1:0]    i_cfg_data
);
    import mbps_pkg::*;

    // input register
    logic                 r_in_valid;
    t_op                  r_op;
    logic [CH_IDX_W-1:0]  r_idx;
    logic [STEP_W-1:0]    r_step;
    logic [PULSE_W-1:0]   r_pulse;
    logic                 r_on;
    logic [AW-1:0]        r_addr;
    logic                 r_sbit;
    logic [COUNT_W-1:0]   r_count;

    logic [PERIOD_W-1:0]  r_period;

    logic      in_accept;
    logic      advance;
    logic      is_tick;
    logic      buf_full;
    logic      playing;
    logic      play_bit;
    logic      chan_level;
    t_chan_cmd chan_cmd;
    t_play_cmd play_cmd;
    t_result   res;
    t_result   out_data;

    assign is_tick    = (r_op == OP_TICK);
    // non-tick commands never need buffer room
    assign advance    = r_in_valid && (!is_tick || !buf_full);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_period   <= PERIOD_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_period <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= t_op'(i_operation);
            r_idx   <= i_channel_index;
            r_step  <= i_step_value;
            r_pulse <= i_pulse_length;
            r_on    <= i_channel_on;
            r_addr  <= i_sample_address;
            // stored bit: byte strictly positive
            r_sbit  <= (i_sample_byte > $signed(BYTE_W'(0)));
            r_count <= i_sample_count;
        end
    end

    // dispatch: playback owns every tick while it runs
    always_comb begin
        chan_cmd.tick  = advance && is_tick && !playing;
        chan_cmd.set   = advance && (r_op == OP_SET_CH);
        chan_cmd.idx   = r_idx;
        chan_cmd.step  = r_step;
        chan_cmd.pulse = r_pulse;
        chan_cmd.on    = r_on;

        play_cmd.tick     = advance && is_tick && playing;
        play_cmd.load     = advance && (r_op == OP_LOAD) &&
                            ({1'b0, r_addr} < (AW + 1)'(SAMPLE_DEPTH));
        play_cmd.start    = advance && (r_op == OP_START);
        play_cmd.load_bit = r_sbit;
        play_cmd.count    = r_count;
        play_cmd.period   = r_period;

        res.audio_bit   = playing ? play_bit : chan_level;
        res.sample_mode = playing;
    end

    mbps_chan #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_chan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (chan_cmd),
        .o_level(chan_level)
    );

    mbps_play #(
        .SAMPLE_DEPTH(SAMPLE_DEPTH)
    ) u_play (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (play_cmd),
        .i_load_addr(r_addr),
        .o_playing  (playing),
        .o_bit      (play_bit)
    );

    mbps_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (advance && is_tick),
        .i_data (res),
        .o_full (buf_full),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_data (out_data)
    );

    assign o_audio_bit   = out_data.audio_bit;
    assign o_sample_mode = out_data.sample_mode;

endmodule
`default_nettype wire
